### rtl/core/rrs_pkg.sv
// rrs_pkg: shared field widths, operation and report codes, register indexes
// and the small rotation helper of the round-robin scheduler
// no dependencies
package rrs_pkg;

	localparam int RB_W      = 8;
	localparam int TIME_W    = 32;
	localparam int TTI_W     = 16;
	localparam int QIU_W     = 4;
	localparam int QIDX_W    = 3;
	localparam int SERVED_W  = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int ENTRY_W   = RB_W + TIME_W;
	localparam int MAX_QUEUES = 8;

	// operation codes of an input item
	localparam logic OP_ENQ  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// report kinds
	localparam logic KIND_ENQ  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RB_PER_TTI    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TTI_LENGTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUES_IN_USE = 2'd2;

	localparam logic [RB_W-1:0]  RB_PER_TTI_RST = 8'd100;
	localparam logic [TTI_W-1:0] TTI_LENGTH_RST = 16'd1;
	localparam logic [QIU_W-1:0] QIU_RST        = 4'd8;

	// s mod n for a narrow start queue, n at least 1
	function automatic logic [QIDX_W-1:0] mod_small(input logic [QIDX_W-1:0] s,
			input logic [QIU_W-1:0] n);
		logic [QIU_W-1:0] r;
		r = {1'b0, s};
		for (int i = 0; i < MAX_QUEUES; i++) begin
			if (r >= n) begin
				r = r - n;
			end
		end
		return r[QIDX_W-1:0];
	endfunction

endpackage

### rtl/core/rrs_ram.sv
// rrs_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/rrs_qstate.sv
// rrs_qstate: per-queue pointer memory (head, tail, fill count) that reads as
// zero until an entry is first written; valid bits cleared by reset
// depends on rrs_ram
module rrs_qstate #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [DEPTH-1:0] valid_q;
	logic             rd_valid_q;
	logic [WIDTH-1:0] ram_rdata;

	rrs_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rd_valid_q ? ram_rdata : '0;

endmodule

### rtl/core/rr_resource_block_scheduler.sv
// rr_resource_block_scheduler: top level, command sequencer around the packet
// store and the per-queue pointer memory
// depends on rrs_pkg, rrs_ram, rrs_qstate

// Round-robin resource block scheduler. An item is taken when start is high
// and busy is low. On an enqueue (operation 0) the accept cycle
// reads the queue's pointer entry, the next cycle writes the packet and the
// updated pointers back; its acknowledgement shows on the result ports for
// one cycle, marked by done, while the block already takes the next item.
// A tick (operation 1) walks the queues in use one at a time through the
// same pointer memory and the packet store: per queue it reads and latches
// the pointer entry, judges each head packet looked at (each served packet
// and the one that blocks the queue) after a registered read of the packet
// store, and writes the pointers back. Each queue gives one report, the
// last with last set. done is a strobe: the receiver cannot hold results
// off, so take every result in the cycle it shows. Configuration writes are
// always ready and must only be made while the block is idle.
module rr_resource_block_scheduler #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           start,
	output logic                           busy,
	input  logic                           operation,
	input  logic [rrs_pkg::QIDX_W-1:0]     queue_index,
	input  logic [rrs_pkg::RB_W-1:0]       packet_rb,
	input  logic [rrs_pkg::TIME_W-1:0]     arrival_time,
	// result channel
	output logic                           done,
	output logic                           report_kind,
	output logic                           accepted,
	output logic [rrs_pkg::QIDX_W-1:0]     report_queue,
	output logic [rrs_pkg::SERVED_W-1:0]   served_count,
	output logic [rrs_pkg::RB_W-1:0]       rb_granted,
	output logic                           starved,
	output logic                           last,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrs_pkg::CFG_DAT_W-1:0]  cfg_data
);

	// queues reachable through a 3-bit index
	localparam int NQ     = (NUM_QUEUES < rrs_pkg::MAX_QUEUES) ? NUM_QUEUES
		: rrs_pkg::MAX_QUEUES;
	localparam int QAW    = (NQ > 1) ? $clog2(NQ) : 1;
	localparam int PW     = $clog2(QUEUE_DEPTH);
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int PEW    = 2 * PW + CW;
	localparam int SDEPTH = NQ * QUEUE_DEPTH;
	localparam int SAW    = $clog2(SDEPTH);
	localparam int EW     = rrs_pkg::ENTRY_W;
	localparam int TW     = rrs_pkg::TIME_W;
	localparam int RW     = rrs_pkg::RB_W;
	localparam int QW     = rrs_pkg::QIDX_W;
	localparam int NW     = rrs_pkg::QIU_W;

	localparam logic [SAW-1:0] DEPTH_S  = SAW'(QUEUE_DEPTH);
	localparam logic [PW-1:0]  PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0]  CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [NW-1:0]  NQ_N     = NW'(NQ);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0; // waiting for a command
	localparam logic [2:0] S_ENQ  = 3'd1; // enqueue read-modify-write
	localparam logic [2:0] S_QRD  = 3'd2; // tick: read pointer entry of queue
	localparam logic [2:0] S_QPTR = 3'd3; // tick: latch head, tail, count
	localparam logic [2:0] S_PRD  = 3'd4; // tick: read head packet
	localparam logic [2:0] S_PKT  = 3'd5; // tick: serve or stop on head packet
	localparam logic [2:0] S_WB   = 3'd6; // tick: write pointers back, report

	logic [2:0] state_q;

	// configuration registers
	logic [RW-1:0]          rb_per_tti_q;
	logic [rrs_pkg::TTI_W-1:0] tti_length_q;
	logic [NW-1:0]          qiu_q;

	// persistent scheduler state
	logic [TW-1:0] time_q;
	logic [QW-1:0] start_queue_q;
	logic [QW-1:0] last_starv_q;

	// command registers
	logic [QW-1:0] eq_q_q;
	logic [RW-1:0] eq_rb_q;
	logic [TW-1:0] eq_arr_q;

	// walk registers
	logic [NW-1:0]               n_q;
	logic [QW-1:0]               q_cur_q;
	logic [QW-1:0]               k_q;
	logic [RW-1:0]               budget_q;
	logic [PW-1:0]               head_q;
	logic [PW-1:0]               tail_q;
	logic [CW-1:0]               cnt_q;
	logic [rrs_pkg::SERVED_W-1:0] served_q;
	logic [RW-1:0]               granted_q;
	logic                        starved_q;

	// result registers
	logic                        done_q;
	logic                        kind_q;
	logic                        acc_q;
	logic [QW-1:0]               rq_q;
	logic [rrs_pkg::SERVED_W-1:0] rs_q;
	logic [RW-1:0]               rg_q;
	logic                        rst_q;
	logic                        rl_q;

	// memory ports
	logic           pt_we;
	logic [QAW-1:0] pt_waddr;
	logic [PEW-1:0] pt_wdata;
	logic [QAW-1:0] pt_raddr;
	logic [PEW-1:0] pt_rdata;
	logic [PW-1:0]  pt_head;
	logic [PW-1:0]  pt_tail;
	logic [CW-1:0]  pt_cnt;

	logic           st_we;
	logic [SAW-1:0] st_waddr;
	logic [EW-1:0]  st_wdata;
	logic [SAW-1:0] st_raddr;
	logic [EW-1:0]  st_rdata;
	logic [RW-1:0]  pkt_rb;
	logic [TW-1:0]  pkt_arr;

	// decoded conditions
	logic           accept;
	logic           enq_ok;
	logic [PW-1:0]  tail_next;
	logic [PW-1:0]  head_next;
	logic [NW-1:0]  n_clamp;
	logic           walk_last;
	logic [QW-1:0]  q_next;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign pt_head = pt_rdata[PEW-1 -: PW];
	assign pt_tail = pt_rdata[CW +: PW];
	assign pt_cnt  = pt_rdata[CW-1:0];
	assign pkt_rb  = st_rdata[EW-1 -: RW];
	assign pkt_arr = st_rdata[TW-1:0];

	// queue index must name an existing queue and the queue must have room
	assign enq_ok    = ({1'b0, eq_q_q} < NQ_N) && (pt_cnt < CNT_FULL);
	assign tail_next = (pt_tail == PTR_LAST) ? '0 : pt_tail + 1'b1;
	assign head_next = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;

	// queues in use: zero counts as one, cut down to the queues that exist
	assign n_clamp = (qiu_q == '0) ? NW'(1) : ((qiu_q > NQ_N) ? NQ_N : qiu_q);

	assign walk_last = (({1'b0, k_q} + NW'(1)) == n_q);
	assign q_next    = (({1'b0, q_cur_q} + NW'(1)) == n_q) ? '0 : q_cur_q + 1'b1;

	// pointer memory: read by the command queue on accept, by the walk in S_QRD
	assign pt_raddr = (state_q == S_IDLE) ? queue_index[QAW-1:0] : q_cur_q[QAW-1:0];
	assign pt_we    = ((state_q == S_ENQ) && enq_ok) || (state_q == S_WB);
	assign pt_waddr = (state_q == S_ENQ) ? eq_q_q[QAW-1:0] : q_cur_q[QAW-1:0];
	assign pt_wdata = (state_q == S_ENQ) ? {pt_head, tail_next, pt_cnt + 1'b1}
		: {head_q, tail_q, cnt_q};

	// packet store: queue-major, one row of QUEUE_DEPTH slots per queue
	assign st_we    = (state_q == S_ENQ) && enq_ok;
	assign st_waddr = SAW'(eq_q_q[QAW-1:0]) * DEPTH_S + SAW'(pt_tail);
	assign st_wdata = {eq_rb_q, eq_arr_q};
	assign st_raddr = SAW'(q_cur_q[QAW-1:0]) * DEPTH_S + SAW'(head_q);

	rrs_qstate #(
		.WIDTH(PEW),
		.DEPTH(NQ)
	) u_qstate (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	rrs_ram #(
		.WIDTH(EW),
		.DEPTH(SDEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_per_tti_q <= rrs_pkg::RB_PER_TTI_RST;
			tti_length_q <= rrs_pkg::TTI_LENGTH_RST;
			qiu_q        <= rrs_pkg::QIU_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rrs_pkg::CFG_RB_PER_TTI:    rb_per_tti_q <= cfg_data[RW-1:0];
				rrs_pkg::CFG_TTI_LENGTH:    tti_length_q <= cfg_data;
				rrs_pkg::CFG_QUEUES_IN_USE: qiu_q <= cfg_data[NW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			time_q        <= '0;
			start_queue_q <= '0;
			last_starv_q  <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == rrs_pkg::OP_ENQ) begin
							state_q <= S_ENQ;
						end else begin
							// a new tick forgets the previous starving queue
							last_starv_q <= '0;
							state_q      <= S_QRD;
						end
					end
				end
				S_ENQ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_QRD: begin
					state_q <= S_QPTR;
				end
				S_QPTR: begin
					// empty queue reports straight away
					state_q <= (pt_cnt == '0) ? S_WB : S_PRD;
				end
				S_PRD: begin
					state_q <= S_PKT;
				end
				S_PKT: begin
					if (pkt_arr > time_q) begin
						state_q <= S_WB;
					end else if (pkt_rb > budget_q) begin
						last_starv_q <= q_cur_q;
						state_q      <= S_WB;
					end else begin
						state_q <= (cnt_q == CW'(1)) ? S_WB : S_PRD;
					end
				end
				S_WB: begin
					done_q <= 1'b1;
					if (walk_last) begin
						time_q        <= time_q + TW'(tti_length_q);
						start_queue_q <= last_starv_q;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_QRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					eq_q_q   <= queue_index;
					eq_rb_q  <= packet_rb;
					eq_arr_q <= arrival_time;
					n_q      <= n_clamp;
					q_cur_q  <= rrs_pkg::mod_small(start_queue_q, n_clamp);
					k_q      <= '0;
					budget_q <= rb_per_tti_q;
				end
			end
			S_ENQ: begin
				kind_q <= rrs_pkg::KIND_ENQ;
				acc_q  <= enq_ok;
				rq_q   <= eq_q_q;
				rs_q   <= '0;
				rg_q   <= '0;
				rst_q  <= 1'b0;
				rl_q   <= 1'b1;
			end
			S_QRD: begin
				served_q  <= '0;
				granted_q <= '0;
				starved_q <= 1'b0;
			end
			S_QPTR: begin
				head_q <= pt_head;
				tail_q <= pt_tail;
				cnt_q  <= pt_cnt;
			end
			S_PKT: begin
				if (pkt_arr > time_q) begin
					// not yet arrived: turn ends without starving
				end else if (pkt_rb > budget_q) begin
					starved_q <= 1'b1;
				end else begin
					budget_q  <= budget_q - pkt_rb;
					granted_q <= granted_q + pkt_rb;
					served_q  <= served_q + 1'b1;
					head_q    <= head_next;
					cnt_q     <= cnt_q - 1'b1;
				end
			end
			S_WB: begin
				kind_q  <= rrs_pkg::KIND_TICK;
				acc_q   <= 1'b0;
				rq_q    <= q_cur_q;
				rs_q    <= served_q;
				rg_q    <= granted_q;
				rst_q   <= starved_q;
				rl_q    <= walk_last;
				k_q     <= k_q + 1'b1;
				q_cur_q <= q_next;
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign report_kind  = kind_q;
	assign accepted     = acc_q;
	assign report_queue = rq_q;
	assign served_count = rs_q;
	assign rb_granted   = rg_q;
	assign starved      = rst_q;
	assign last         = rl_q;

`ifndef SYNTH
	// a result only follows an enqueue update or a queue write-back
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_ENQ || state_q == S_WB))
		else $error("result strobe without a producing state");

	// tick reports never carry an acceptance
	a_tick_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && report_kind == rrs_pkg::KIND_TICK) |-> !accepted)
		else $error("tick report marked accepted");

	// a packet is only looked at while the queue holds one
	a_pkt_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PKT) |-> (cnt_q != '0))
		else $error("packet read from an empty queue");

	// the final tick report leaves the block ready for a command
	a_tick_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last && report_kind == rrs_pkg::KIND_TICK) |-> !busy)
		else $error("block still busy after final tick report");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking regression of rr_resource_block_scheduler,
// with a command driver, a result monitor and a scheduling predictor
// depends on rrs_pkg and the scheduler rtl
module testbench;

	localparam int RB_W      = rrs_pkg::RB_W;
	localparam int TIME_W    = rrs_pkg::TIME_W;
	localparam int TTI_W     = rrs_pkg::TTI_W;
	localparam int QIU_W     = rrs_pkg::QIU_W;
	localparam int QIDX_W    = rrs_pkg::QIDX_W;
	localparam int SERVED_W  = rrs_pkg::SERVED_W;
	localparam int CFG_IDX_W = rrs_pkg::CFG_IDX_W;
	localparam int CFG_DAT_W = rrs_pkg::CFG_DAT_W;

	localparam int N_QUEUES  = 8;
	localparam int Q_DEPTH   = 64;
	localparam int PTR_W     = $clog2(Q_DEPTH);
	localparam int PRINT_CAP = 40;
	// the register map leaves this index unused, a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic              op;
		logic [QIDX_W-1:0] q;
		logic [RB_W-1:0]   rb;
		logic [TIME_W-1:0] arrival;
		logic              hold;    // driver waits until nothing is outstanding
	} sched_cmd_t;

	typedef struct packed {
		logic                kind;
		logic                acc;
		logic [QIDX_W-1:0]   q;
		logic [SERVED_W-1:0] served;
		logic [RB_W-1:0]     granted;
		logic                starved;
		logic                last;
	} sched_report_t;

	// clock, reset and block ports
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 start        = 1'b0;
	logic                 busy;
	logic                 operation    = rrs_pkg::OP_ENQ;
	logic [QIDX_W-1:0]    queue_index  = '0;
	logic [RB_W-1:0]      packet_rb    = '0;
	logic [TIME_W-1:0]    arrival_time = '0;
	logic                 done;
	logic                 report_kind;
	logic                 accepted;
	logic [QIDX_W-1:0]    report_queue;
	logic [SERVED_W-1:0]  served_count;
	logic [RB_W-1:0]      rb_granted;
	logic                 starved;
	logic                 last;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;

	// predictor copy of the queues, the clock of the schedule and the registers
	logic [RB_W-1:0]   pkt_size    [N_QUEUES][Q_DEPTH];
	logic [TIME_W-1:0] pkt_arrival [N_QUEUES][Q_DEPTH];
	logic [PTR_W-1:0]  head_ptr    [N_QUEUES];
	logic [PTR_W-1:0]  tail_ptr    [N_QUEUES];
	int unsigned       fill        [N_QUEUES];
	logic [TIME_W-1:0] now_time    = '0;
	logic [QIDX_W-1:0] rotate_from = '0;
	logic [RB_W-1:0]   budget_cfg  = rrs_pkg::RB_PER_TTI_RST;
	logic [TTI_W-1:0]  tti_cfg     = rrs_pkg::TTI_LENGTH_RST;
	logic [QIU_W-1:0]  qiu_cfg     = rrs_pkg::QIU_RST;

	// commands waiting for a transfer, and reports still owed by the block
	sched_cmd_t    pending_cmds[$];
	sched_report_t expected_reports[$];

	// time the planner expects the block to have when a planned item lands
	logic [TIME_W-1:0] plan_time       = '0;
	int unsigned       sender_idle_pct = 0;

	int unsigned mismatches     = 0;
	int unsigned checked        = 0;
	int unsigned enq_taken      = 0;
	int unsigned enq_refused    = 0;
	int unsigned ticks_run      = 0;
	int unsigned starve_reports = 0;
	int unsigned cfg_writes     = 0;

	rr_resource_block_scheduler #(
		.NUM_QUEUES (N_QUEUES),
		.QUEUE_DEPTH(Q_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.queue_index (queue_index),
		.packet_rb   (packet_rb),
		.arrival_time(arrival_time),
		.done        (done),
		.report_kind (report_kind),
		.accepted    (accepted),
		.report_queue(report_queue),
		.served_count(served_count),
		.rb_granted  (rb_granted),
		.starved     (starved),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < PRINT_CAP) begin
			$display("%0t mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	// works out the reports of one transferred command and updates the copy
	task automatic predict_reports(input sched_cmd_t c);
		sched_report_t     r;
		int unsigned       n;
		int unsigned       budget;
		int unsigned       qv;
		logic [QIDX_W-1:0] starve_q;
		r = '0;
		if (c.op == rrs_pkg::OP_ENQ) begin
			r.kind = rrs_pkg::KIND_ENQ;
			r.q    = c.q;
			r.last = 1'b1;
			// every 3-bit index names a real queue, so only a full queue refuses
			if (fill[c.q] < Q_DEPTH) begin
				pkt_size[c.q][tail_ptr[c.q]]    = c.rb;
				pkt_arrival[c.q][tail_ptr[c.q]] = c.arrival;
				tail_ptr[c.q] = (tail_ptr[c.q] == Q_DEPTH - 1) ? '0 : tail_ptr[c.q] + 1'b1;
				fill[c.q]++;
				r.acc = 1'b1;
				enq_taken++;
			end else begin
				enq_refused++;
			end
			expected_reports.push_back(r);
		end else begin
			// zero queues in use counts as one, too many is cut to the queue count
			n = (qiu_cfg == 0) ? 1 : qiu_cfg;
			if (n > N_QUEUES) begin
				n = N_QUEUES;
			end
			budget   = {24'd0, budget_cfg};
			starve_q = '0;
			for (int k = 0; k < n; k++) begin
				// start queue past the queues in use wraps around them
				qv     = (rotate_from + k) % n;
				r      = '0;
				r.kind = rrs_pkg::KIND_TICK;
				r.q    = QIDX_W'(qv);
				while (fill[qv] > 0) begin
					// a head that has not arrived ends the turn without starving
					if (pkt_arrival[qv][head_ptr[qv]] > now_time) begin
						break;
					end
					// a head over the remaining budget starves the queue
					if (pkt_size[qv][head_ptr[qv]] > budget) begin
						starve_q  = QIDX_W'(qv);
						r.starved = 1'b1;
						break;
					end
					budget    -= pkt_size[qv][head_ptr[qv]];
					r.granted += pkt_size[qv][head_ptr[qv]];
					r.served++;
					head_ptr[qv] = (head_ptr[qv] == Q_DEPTH - 1) ? '0 : head_ptr[qv] + 1'b1;
					fill[qv]--;
				end
				r.last = (k == n - 1);
				if (r.starved) begin
					starve_reports++;
				end
				expected_reports.push_back(r);
			end
			now_time    = now_time + tti_cfg;
			rotate_from = starve_q;
			ticks_run++;
		end
	endtask

	// command driver: start stays up from one transfer to the next when
	// another command is ready, so each signal gets one update per edge
	always @(posedge clk or negedge arst_n) begin
		logic       presenting;
		sched_cmd_t nxt;
		if (!arst_n) begin
			start        <= 1'b0;
			operation    <= rrs_pkg::OP_ENQ;
			queue_index  <= '0;
			packet_rb    <= '0;
			arrival_time <= '0;
		end else begin
			presenting = start;
			if (start && !busy) begin
				nxt = pending_cmds.pop_front();
				predict_reports(nxt);
				presenting = 1'b0;
			end
			if (!presenting) begin
				if (pending_cmds.size() != 0 &&
						!(pending_cmds[0].hold && expected_reports.size() != 0) &&
						$urandom_range(0, 99) >= sender_idle_pct) begin
					nxt = pending_cmds[0];
					start        <= 1'b1;
					operation    <= nxt.op;
					queue_index  <= nxt.q;
					packet_rb    <= nxt.rb;
					arrival_time <= nxt.arrival;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want, input logic [QIDX_W-1:0] q);
		if (got !== want) begin
			flag_mismatch($sformatf("%s of queue %0d: got %0d, want %0d", name, q, got, want));
		end
	endtask

	// result monitor: done is a strobe, every report is taken in its cycle
	always @(posedge clk) begin
		sched_report_t got;
		sched_report_t want;
		if (arst_n && done) begin
			got = {report_kind, accepted, report_queue, served_count, rb_granted, starved, last};
			if (expected_reports.size() == 0) begin
				flag_mismatch($sformatf("report for queue %0d with nothing outstanding", got.q));
			end else begin
				want = expected_reports.pop_front();
				compare_field("report_kind", 32'(got.kind), 32'(want.kind), want.q);
				compare_field("accepted", 32'(got.acc), 32'(want.acc), want.q);
				compare_field("report_queue", 32'(got.q), 32'(want.q), want.q);
				compare_field("served_count", 32'(got.served), 32'(want.served), want.q);
				compare_field("rb_granted", 32'(got.granted), 32'(want.granted), want.q);
				compare_field("starved", 32'(got.starved), 32'(want.starved), want.q);
				compare_field("last", 32'(got.last), 32'(want.last), want.q);
				checked++;
			end
		end
	end

	task automatic push_cmd(input logic op, input logic [QIDX_W-1:0] q,
			input logic [RB_W-1:0] sz, input logic [TIME_W-1:0] arr, input logic hold);
		sched_cmd_t c;
		c.op      = op;
		c.q       = q;
		c.rb      = sz;
		c.arrival = arr;
		c.hold    = hold;
		pending_cmds.push_back(c);
	endtask

	// register write, only made while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (idx)
			rrs_pkg::CFG_RB_PER_TTI:    budget_cfg = val[RB_W-1:0];
			rrs_pkg::CFG_TTI_LENGTH:    tti_cfg    = val[TTI_W-1:0];
			rrs_pkg::CFG_QUEUES_IN_USE: qiu_cfg    = val[QIU_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// wait until every command went over and every report came back
	task automatic settle();
		do begin
			@(negedge clk);
		end while (pending_cmds.size() != 0 || start || expected_reports.size() != 0 || busy);
		repeat (4) @(negedge clk);
	endtask

	// random phase: mostly enqueues of packets that arrive around the ticks,
	// some ticks, optionally one burst that overfills a queue
	task automatic plan_phase(input int unsigned count, input int unsigned idle_pct,
			input bit with_burst, input bit hold_first);
		int unsigned       n_vis;
		int unsigned       pick;
		logic [TIME_W-1:0] lag;
		logic [TIME_W-1:0] arr;
		logic [QIDX_W-1:0] q;
		logic [RB_W-1:0]   sz;
		logic              hold;
		@(negedge clk);
		sender_idle_pct = idle_pct;
		plan_time       = now_time;
		n_vis = (qiu_cfg == 0) ? 1 : ((qiu_cfg > N_QUEUES) ? N_QUEUES : qiu_cfg);
		for (int i = 0; i < count; i++) begin
			if (with_burst && i == count / 2) begin
				q = QIDX_W'($urandom_range(0, n_vis - 1));
				for (int j = 0; j < Q_DEPTH + 2; j++) begin
					push_cmd(rrs_pkg::OP_ENQ, q, RB_W'($urandom_range(0, 8)), plan_time, 1'b0);
				end
			end
			hold = (hold_first && i == 0) || (idle_pct != 0 && $urandom_range(0, 99) < 3);
			if ($urandom_range(0, 99) < 20) begin
				// unused fields of a tick carry noise
				push_cmd(rrs_pkg::OP_TICK, QIDX_W'($urandom), RB_W'($urandom), $urandom, hold);
				plan_time = plan_time + tti_cfg;
			end else begin
				q = ($urandom_range(0, 99) < 80) ? QIDX_W'($urandom_range(0, n_vis - 1))
					: QIDX_W'($urandom_range(0, N_QUEUES - 1));
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					sz = '0;
				end else if (pick < 10) begin
					sz = '1;
				end else if (pick < 25) begin
					sz = RB_W'($urandom_range(1, 255));
				end else begin
					sz = RB_W'($urandom_range(1, 40));
				end
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					lag = $urandom_range(0, 3) * tti_cfg;
					arr = (plan_time >= lag) ? plan_time - lag : '0;
				end else if (pick < 85) begin
					arr = plan_time + $urandom_range(1, 3) * tti_cfg;
				end else begin
					arr = '0;
				end
				push_cmd(rrs_pkg::OP_ENQ, q, sz, arr, hold);
			end
		end
	endtask

	initial begin : stimulus
		logic [CFG_DAT_W-1:0] word;
		for (int i = 0; i < N_QUEUES; i++) begin
			head_ptr[i] = '0;
			tail_ptr[i] = '0;
			fill[i]     = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed part under the reset settings: 100 blocks, 8 queues, time step 1
		@(negedge clk);
		push_cmd(rrs_pkg::OP_ENQ, 3'd0, 8'd255, 32'd0, 1'b0);  // larger than the budget, starves
		push_cmd(rrs_pkg::OP_ENQ, 3'd1, 8'd0, 32'd0, 1'b0);    // zero-sized packet, free
		push_cmd(rrs_pkg::OP_ENQ, 3'd2, 8'd60, 32'd0, 1'b0);
		push_cmd(rrs_pkg::OP_ENQ, 3'd2, 8'd50, 32'd0, 1'b0);   // only 40 left after the first
		push_cmd(rrs_pkg::OP_ENQ, 3'd7, 8'd1, 32'd2, 1'b0);    // arrives two ticks later
		push_cmd(rrs_pkg::OP_ENQ, 3'd5, 8'd1, 32'd1, 1'b0);    // not arrived on the first tick
		push_cmd(rrs_pkg::OP_TICK, 3'd0, 8'd0, 32'd0, 1'b0);
		// resumes at the starving queue
		push_cmd(rrs_pkg::OP_TICK, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b0);
		push_cmd(rrs_pkg::OP_ENQ, 3'd6, 8'd200, 32'd0, 1'b0);  // later starving queue wins
		push_cmd(rrs_pkg::OP_ENQ, 3'd4, 8'd30, 32'd0, 1'b0);
		push_cmd(rrs_pkg::OP_TICK, 3'd0, 8'd0, 32'd0, 1'b0);
		settle();

		// start queue 6 lands past five queues in use
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, 16'h0005);
		plan_phase(40, 69, 1'b0, 1'b1);
		settle();

		// all ones in the budget and time step registers, eight queues in use, long time steps
		write_reg(rrs_pkg::CFG_RB_PER_TTI, 16'hFFFF);
		write_reg(rrs_pkg::CFG_TTI_LENGTH, 16'hFFFF);
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, 16'h0008);
		plan_phase(40, 0, 1'b1, 1'b0);
		settle();

		// one block per interval, time frozen, zero queues in use
		write_reg(rrs_pkg::CFG_RB_PER_TTI, 16'h0001);
		write_reg(rrs_pkg::CFG_TTI_LENGTH, 16'h0000);
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, 16'h0000);
		plan_phase(30, 17, 1'b0, 1'b0);
		settle();

		// zero budget: only zero-sized packets pass; queue count above the maximum
		write_reg(rrs_pkg::CFG_RB_PER_TTI, 16'hFF00);
		write_reg(rrs_pkg::CFG_TTI_LENGTH, 16'h0003);
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, 16'h000F);
		plan_phase(30, 69, 1'b0, 1'b0);
		settle();

		// random settings, plus a write to the unused index
		word       = CFG_DAT_W'($urandom);
		word[7:0]  = RB_W'($urandom_range(128, 255));
		write_reg(rrs_pkg::CFG_RB_PER_TTI, word);
		write_reg(rrs_pkg::CFG_TTI_LENGTH, CFG_DAT_W'($urandom_range(1, 16)));
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, 16'h0009);
		write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
		plan_phase(40, 0, 1'b1, 1'b0);
		settle();

		word      = CFG_DAT_W'($urandom);
		word[7:0] = RB_W'($urandom_range(1, 255));
		write_reg(rrs_pkg::CFG_RB_PER_TTI, word);
		write_reg(rrs_pkg::CFG_TTI_LENGTH, CFG_DAT_W'($urandom_range(1, 1000)));
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, CFG_DAT_W'($urandom_range(1, 8)));
		plan_phase(30, 17, 1'b0, 1'b0);
		settle();

		write_reg(rrs_pkg::CFG_RB_PER_TTI, 16'h0080);
		write_reg(rrs_pkg::CFG_TTI_LENGTH, 16'h0002);
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, 16'h0003);
		plan_phase(40, 69, 1'b0, 1'b0);
		settle();

		// short random tail at single time steps
		write_reg(rrs_pkg::CFG_RB_PER_TTI, 16'h00C8);
		write_reg(rrs_pkg::CFG_TTI_LENGTH, 16'h0001);
		write_reg(rrs_pkg::CFG_QUEUES_IN_USE, 16'h0008);
		plan_phase(20, 17, 1'b0, 1'b0);
		settle();
		repeat (20) @(negedge clk);

		$display("covered %0d enqueues (%0d stored, %0d refused) and %0d ticks, %0d starving",
			enq_taken + enq_refused, enq_taken, enq_refused, ticks_run, starve_reports);
		$display("checked %0d reports across %0d register writes", checked, cfg_writes);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("rr_resource_block_scheduler regression: pass");
		end else begin
			$display("rr_resource_block_scheduler regression: fail");
		end
		$finish;
	end

	// generous bound, several times the slowest correct run
	initial begin : watchdog
		#(30_000_000);
		$display("rr_resource_block_scheduler regression: fail");
		$finish;
	end

endmodule
